>>> rtl/bchc_pkg.sv
// bchc_pkg: shared constants and request codes for the colour histogram classifier
// no dependencies; used by the channel interfaces and the top level

package bchc_pkg;

   localparam int COLOR_BITS_DEF = 5;
   localparam int COUNT_BITS_DEF = 16;

   localparam int CH_W    = 8;   // one colour channel
   localparam int PROB_W  = 16;  // Q0.16 probability
   localparam int TOTAL_W = 32;  // running pixel totals
   localparam int STEP_W  = $clog2(PROB_W);

   localparam logic REQ_TRAIN = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

endpackage

>>> rtl/bchc_req_if.sv
// bchc_req_if: pixel request channel (train or query) with valid/ready
// depends on bchc_pkg for the channel width

interface bchc_req_if import bchc_pkg::*; ();

   logic            valid;
   logic            ready;
   logic            req_type;
   logic [CH_W-1:0] blue;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] red;
   logic            is_skin;

   modport source (output valid, output req_type, output blue, output green, output red,
                   output is_skin, input ready);
   modport sink   (input valid, input req_type, input blue, input green, input red,
                   input is_skin, output ready);

endinterface

>>> rtl/bchc_rsp_if.sv
// bchc_rsp_if: result channel carrying the skin probability and running totals
// depends on bchc_pkg for the field widths

interface bchc_rsp_if import bchc_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [PROB_W-1:0]  probability;
   logic [TOTAL_W-1:0] skin_pixels_seen;
   logic [TOTAL_W-1:0] other_pixels_seen;

   modport source (output valid, output probability, output skin_pixels_seen,
                   output other_pixels_seen, input ready);
   modport sink   (input valid, input probability, input skin_pixels_seen,
                   input other_pixels_seen, output ready);

endinterface

>>> rtl/bchc_ram.sv
// bchc_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies

module bchc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bayes_color_histogram_classifier.sv
// bayes_color_histogram_classifier: histogram based skin colour trainer and classifier
// depends on bchc_pkg, bchc_req_if, bchc_rsp_if and bchc_ram
//
//   channel    direction  handshake      payload
//   req_chan   in         valid/ready    req_type, blue, green, red, is_skin
//   rsp_chan   out        valid/ready    probability, skin_pixels_seen, other_pixels_seen
//
// one item is in flight at a time; a training item passes read, update and output, a query
// read, setup, 16 restoring divide steps and output (no divide if the entry's all count or
// the skin total is zero); a new request is taken once the result is loaded, back in idle
// the histogram lives in one RAM with a registered read
// after reset a clearing pass writes zero to all 2^(3*COLOR_BITS) entries
// (32768 entries at the default) before the first request is taken
// a new request is taken while the previous result still waits in the output register

module bayes_color_histogram_classifier import bchc_pkg::*; #(
   parameter int COLOR_BITS = COLOR_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bchc_req_if.sink   req_chan,
   bchc_rsp_if.source rsp_chan
);

   localparam int ADDR_W  = 3 * COLOR_BITS;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int ENTRY_W = 2 * COUNT_BITS;
   localparam int NUM_W   = COUNT_BITS + PROB_W;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_EXEC  = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  type_ff, type_in;
   logic                  skin_ff, skin_in;
   logic [TOTAL_W-1:0]    skin_total_ff, skin_total_in;
   logic [TOTAL_W-1:0]    other_total_ff, other_total_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [PROB_W-1:0]     low_ff, low_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]     rsp_prob_ff, rsp_prob_in;
   logic [TOTAL_W-1:0]    rsp_skin_ff, rsp_skin_in;
   logic [TOTAL_W-1:0]    rsp_other_ff, rsp_other_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  rd_en;
   logic [ENTRY_W-1:0]    rd_data;

   logic [COUNT_BITS-1:0] skin_cnt, all_cnt;
   logic [COUNT_BITS-1:0] skin_cnt_inc, all_cnt_inc;
   logic [NUM_W-1:0]      num;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;
   logic                  req_xfer, rsp_load, out_free;

   bchc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load       = (state_ff == S_DONE) && out_free;

   // entry layout: skin count above all count
   assign skin_cnt     = rd_data[ENTRY_W-1:COUNT_BITS];
   assign all_cnt      = rd_data[COUNT_BITS-1:0];
   assign skin_cnt_inc = (skin_cnt == '1) ? skin_cnt : skin_cnt + 1'b1;
   assign all_cnt_inc  = (all_cnt == '1) ? all_cnt : all_cnt + 1'b1;

   // skin * 65535 + all / 2, done as a shift and subtract
   assign num = {skin_cnt, {PROB_W{1'b0}}} - NUM_W'(skin_cnt) + NUM_W'(all_cnt >> 1);

   // restoring divide step, quotient shifts into low_ff as the numerator shifts out
   assign trial = {rem_ff, low_ff[PROB_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   assign rd_en = (state_ff == S_READ);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = {skin_ff ? skin_cnt_inc : skin_cnt, all_cnt_inc};
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (state_ff == S_EXEC && type_ff == REQ_TRAIN) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      addr_in        = addr_ff;
      type_in        = type_ff;
      skin_in        = skin_ff;
      skin_total_in  = skin_total_ff;
      other_total_in = other_total_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      low_in         = low_ff;
      step_in        = step_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               addr_in  = {req_chan.blue[CH_W-1 -: COLOR_BITS],
                           req_chan.green[CH_W-1 -: COLOR_BITS],
                           req_chan.red[CH_W-1 -: COLOR_BITS]};
               type_in  = req_chan.req_type;
               skin_in  = req_chan.is_skin;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            low_in   = '0;
            state_in = S_DONE;
            if (type_ff == REQ_TRAIN) begin
               if (skin_ff) begin
                  if (skin_total_ff != '1) skin_total_in = skin_total_ff + 1'b1;
               end else begin
                  if (other_total_ff != '1) other_total_in = other_total_ff + 1'b1;
               end
            end else if (all_cnt != '0 && skin_total_ff != '0) begin
               rem_in   = num[NUM_W-1:PROB_W];
               low_in   = num[PROB_W-1:0];
               den_in   = all_cnt;
               step_in  = STEP_W'(PROB_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = fits ? COUNT_BITS'(trial - {1'b0, den_ff}) : trial[COUNT_BITS-1:0];
            low_in  = {low_ff[PROB_W-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_skin_in  = rsp_skin_ff;
      rsp_other_in = rsp_other_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_prob_in  = low_ff;
         rsp_skin_in  = skin_total_ff;
         rsp_other_in = other_total_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         step_ff        <= '0;
         skin_total_ff  <= '0;
         other_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         step_ff        <= step_in;
         skin_total_ff  <= skin_total_in;
         other_total_ff <= other_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      type_ff      <= type_in;
      skin_ff      <= skin_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      low_ff       <= low_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_skin_ff  <= rsp_skin_in;
      rsp_other_ff <= rsp_other_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.probability       = rsp_prob_ff;
   assign rsp_chan.skin_pixels_seen  = rsp_skin_ff;
   assign rsp_chan.other_pixels_seen = rsp_other_ff;

endmodule
